>>> design/pbts_pkg.sv
// Package of the priority bitmap task scheduler.
// Holds the operation codes, field widths and the command record passed
// from the front end to the back end. Depends on nothing.
package pbts_pkg;

   // Fixed widths of the item fields.
   localparam int OP_W       = 3;
   localparam int TASK_ID_W  = 4;
   localparam int PRIO_IN_W  = 5;
   localparam int TICKS_W    = 24;
   localparam int SLICE_W    = 8;
   localparam int LOCK_W     = 8;
   localparam int RDY_OUT_W  = 32;
   localparam int CMD_PRIO_W = 6;

   // Lock count ceiling and slice count after reset.
   localparam logic [LOCK_W-1:0]  LOCK_MAX    = 8'd255;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

   // Queue between the front end and the back end.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = 1;
   localparam int FIFO_CW    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_READY    = 3'd0,
      OP_UNREADY  = 3'd1,
      OP_DELAY    = 3'd2,
      OP_UNDELAY  = 3'd3,
      OP_LOCK     = 3'd4,
      OP_UNLOCK   = 3'd5,
      OP_TICK     = 3'd6,
      OP_SCHEDULE = 3'd7
   } op_type;

   // One classified item: priority already saturated, zero delay made one.
   typedef struct packed {
      op_type                  op;
      logic                    task_ok;
      logic [TASK_ID_W-1:0]    task_id;
      logic [CMD_PRIO_W-1:0]   prio;
      logic [TICKS_W-1:0]      ticks;
   } cmd_type;

endpackage

>>> design/pbts_front.sv
// Front end of the priority bitmap task scheduler.
// Accepts items, classifies them into cmd_type records and queues them
// for the back end. Depends on pbts_pkg.
module pbts_front #(
   parameter int NUM_TASKS = 16,
   parameter int NUM_PRIOS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pbts_pkg::OP_W-1:0]      req_operation,
   input  logic [pbts_pkg::TASK_ID_W-1:0] req_task_id,
   input  logic [pbts_pkg::PRIO_IN_W-1:0] req_task_priority,
   input  logic [pbts_pkg::TICKS_W-1:0]   req_delay_ticks,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output pbts_pkg::cmd_type             cmd
);
   import pbts_pkg::*;

   cmd_type              cmd_new;
   cmd_type              fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 push, pop;

   // Classify the incoming item.
   always_comb begin
      cmd_new.op      = op_type'(req_operation);
      cmd_new.task_ok = int'(req_task_id) < NUM_TASKS;
      cmd_new.task_id = req_task_id;
      if (int'(req_task_priority) >= NUM_PRIOS) begin
         cmd_new.prio = CMD_PRIO_W'(NUM_PRIOS - 1);
      end else begin
         cmd_new.prio = CMD_PRIO_W'(req_task_priority);
      end
      if (req_delay_ticks == '0) begin
         cmd_new.ticks = TICKS_W'(1);
      end else begin
         cmd_new.ticks = req_delay_ticks;
      end
   end

   // Handshakes and queue pointers.
   assign req_ready = count_ff != FIFO_CW'(FIFO_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd       = fifo_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   // Queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/pbts_back.sv
// Back end of the priority bitmap task scheduler.
// Sequencer that carries out one command at a time over the ready queues,
// the delay list and the slice counts, and holds the result register.
// Depends on pbts_pkg.
module pbts_back #(
   parameter int NUM_TASKS = 16,
   parameter int NUM_PRIOS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  pbts_pkg::cmd_type              cmd,
   input  logic                           csr_valid,
   input  logic [pbts_pkg::SLICE_W-1:0]    csr_time_slice_ticks,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pbts_pkg::TASK_ID_W-1:0]  rsp_next_task,
   output logic                           rsp_switch_request,
   output logic [pbts_pkg::RDY_OUT_W-1:0]  rsp_ready_priorities
);
   import pbts_pkg::*;

   localparam int TW = $clog2(NUM_TASKS);
   localparam int PW = $clog2(NUM_PRIOS);
   localparam int CW = $clog2(NUM_TASKS + 1);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_DISPATCH  = 13'b0000000000010,
      S_RM_START  = 13'b0000000000100,
      S_RM_HEAD   = 13'b0000000001000,
      S_RM_WALK   = 13'b0000000010000,
      S_DL_ADD    = 13'b0000000100000,
      S_DR_WALK   = 13'b0000001000000,
      S_TK_STEP   = 13'b0000010000000,
      S_TK_PUSH   = 13'b0000100000000,
      S_CHARGE    = 13'b0001000000000,
      S_PUSH_TAIL = 13'b0010000000000,
      S_SCHED     = 13'b0100000000000,
      S_FINISH    = 13'b1000000000000
   } state_type;

   // Stores without reset; read only where a flag shows they were written.
   logic [TW-1:0]      head_ff  [NUM_PRIOS];
   logic [TW-1:0]      tail_ff  [NUM_PRIOS];
   logic [TW-1:0]      qlink_ff [NUM_TASKS];
   logic [PW-1:0]      sp_ff    [NUM_TASKS];
   logic [TICKS_W-1:0] dl_ff    [NUM_TASKS];
   logic [TW-1:0]      dlink_ff [NUM_TASKS];
   logic [SLICE_W-1:0] sl_ff    [NUM_TASKS];

   // Write ports of the stores.
   logic               head_we, tail_we, qlink_we, sp_we, dl_we, dlink_we, sl_we;
   logic [TW-1:0]      head_wd, tail_wd, qlink_wd, qlink_wa, dlink_wd, dlink_wa;
   logic [TW-1:0]      dl_wa;
   logic [TICKS_W-1:0] dl_wd;
   logic [SLICE_W-1:0] sl_wd;

   // Read ports of the stores.
   logic [PW-1:0]      qp;
   logic [TW-1:0]      sp_ra;
   logic [TW-1:0]      head_rd, tail_rd, qlink_rd, dlink_rd;
   logic [PW-1:0]      sp_rd;
   logic [TICKS_W-1:0] dl_rd, dl_dec;
   logic [SLICE_W-1:0] sl_rd, sl_dec;

   // Control state.
   state_type          state_ff, state_in;
   logic [NUM_PRIOS-1:0] bm_ff, bm_in, bm_iso;
   logic [NUM_TASKS-1:0] inq_ff, inq_in;
   logic [NUM_TASKS-1:0] dmark_ff, dmark_in;
   logic [NUM_TASKS-1:0] sl_vld_ff, sl_vld_in;
   logic [TW-1:0]      dfirst_ff, dfirst_in, dlast_ff, dlast_in;
   logic               dne_ff, dne_in;
   logic [LOCK_W-1:0]  lock_ff, lock_in;
   logic [TW-1:0]      rt_ff, rt_in;
   logic               rv_ff, rv_in;
   logic [SLICE_W-1:0] tst_ff, tst_in;

   // Working registers of the current item.
   op_type             op_ff, op_in;
   logic               ok_ff, ok_in;
   logic [PW-1:0]      prio_ff, prio_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [TW-1:0]      wt_ff, wt_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [TW-1:0]      nxt_ff, nxt_in, chosen_ff, chosen_in;
   logic [PW-1:0]      rp_ff, rp_in;
   logic               hp_ff, hp_in, last_ff, last_in, sw_ff, sw_in;
   logic [CW-1:0]      n_ff, n_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in, rsp_sw_ff, rsp_sw_in;
   logic [TASK_ID_W-1:0] rsp_next_ff, rsp_next_in;
   logic [RDY_OUT_W-1:0] rsp_rdy_ff, rsp_rdy_in;

   logic [PW-1:0]      enc;
   logic               walk_end, stop, expired;

   // Lowest-numbered non-empty priority.
   always_comb begin
      bm_iso = bm_ff & (~bm_ff + 1'b1);
      enc    = '0;
      for (int i = 0; i < NUM_PRIOS; i++) begin
         if (bm_iso[i]) begin
            enc = enc | PW'(i);
         end
      end
   end

   // Priority addressed by the queue stores in this state.
   always_comb begin
      sp_ra = (state_ff == S_TK_PUSH) ? cur_ff : wt_ff;
      sp_rd = sp_ff[sp_ra];
      case (state_ff)
         S_RM_HEAD, S_RM_WALK:   qp = rp_ff;
         S_TK_PUSH, S_PUSH_TAIL: qp = sp_rd;
         S_SCHED:                qp = enc;
         default:                qp = prio_ff;
      endcase
   end

   assign head_rd  = head_ff[qp];
   assign tail_rd  = tail_ff[qp];
   assign qlink_rd = qlink_ff[cur_ff];
   assign dlink_rd = dlink_ff[cur_ff];
   assign dl_rd    = dl_ff[cur_ff];
   assign dl_dec   = dl_rd - TICKS_W'(1);
   assign expired  = dl_dec == '0;
   assign sl_rd    = sl_vld_ff[wt_ff] ? sl_ff[wt_ff] : SLICE_RESET;
   assign sl_dec   = sl_rd - SLICE_W'(1);
   assign walk_end = n_ff == CW'(NUM_TASKS - 1);

   assign cmd_ready            = state_ff == S_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_next_task        = rsp_next_ff;
   assign rsp_switch_request   = rsp_sw_ff;
   assign rsp_ready_priorities = rsp_rdy_ff;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      bm_in     = bm_ff;
      inq_in    = inq_ff;
      dmark_in  = dmark_ff;
      sl_vld_in = sl_vld_ff;
      dfirst_in = dfirst_ff;
      dlast_in  = dlast_ff;
      dne_in    = dne_ff;
      lock_in   = lock_ff;
      rt_in     = rt_ff;
      rv_in     = rv_ff;
      tst_in    = csr_valid ? csr_time_slice_ticks : tst_ff;
      op_in     = op_ff;
      ok_in     = ok_ff;
      prio_in   = prio_ff;
      ticks_in  = ticks_ff;
      wt_in     = wt_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      nxt_in    = nxt_ff;
      chosen_in = chosen_ff;
      rp_in     = rp_ff;
      hp_in     = hp_ff;
      last_in   = last_ff;
      sw_in     = sw_ff;
      n_in      = n_ff;
      stop      = 1'b0;
      head_we   = 1'b0;
      head_wd   = wt_ff;
      tail_we   = 1'b0;
      tail_wd   = wt_ff;
      qlink_we  = 1'b0;
      qlink_wa  = wt_ff;
      qlink_wd  = head_rd;
      sp_we     = 1'b0;
      dl_we     = 1'b0;
      dl_wa     = wt_ff;
      dl_wd     = ticks_ff;
      dlink_we  = 1'b0;
      dlink_wa  = prev_ff;
      dlink_wd  = dlink_rd;
      sl_we     = 1'b0;
      sl_wd     = sl_dec;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sw_in    = rsp_sw_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_rdy_in   = rsp_rdy_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               op_in     = cmd.op;
               ok_in     = cmd.task_ok;
               prio_in   = PW'(cmd.prio);
               ticks_in  = cmd.ticks;
               wt_in     = TW'(cmd.task_id);
               sw_in     = 1'b0;
               chosen_in = '0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (op_ff)
               OP_READY: begin
                  if (ok_ff && !inq_ff[wt_ff]) begin
                     sp_we = 1'b1;
                     if (bm_ff[qp]) begin
                        qlink_we = 1'b1;
                     end else begin
                        tail_we = 1'b1;
                     end
                     head_we       = 1'b1;
                     bm_in[qp]     = 1'b1;
                     inq_in[wt_ff] = 1'b1;
                  end
               end
               OP_UNREADY: begin
                  if (ok_ff && inq_ff[wt_ff]) begin
                     state_in = S_RM_START;
                  end
               end
               OP_DELAY: begin
                  if (ok_ff && !dmark_ff[wt_ff]) begin
                     state_in = inq_ff[wt_ff] ? S_RM_START : S_DL_ADD;
                  end
               end
               OP_UNDELAY: begin
                  if (ok_ff && dmark_ff[wt_ff] && dne_ff) begin
                     cur_in   = dfirst_ff;
                     hp_in    = 1'b0;
                     n_in     = '0;
                     state_in = S_DR_WALK;
                  end
               end
               OP_LOCK: begin
                  if (lock_ff != LOCK_MAX) begin
                     lock_in = lock_ff + 1'b1;
                  end
               end
               OP_UNLOCK: begin
                  if (lock_ff != '0) begin
                     lock_in = lock_ff - 1'b1;
                     if (lock_ff == LOCK_W'(1)) begin
                        state_in = S_SCHED;
                     end
                  end
               end
               OP_TICK: begin
                  wt_in = rt_ff;
                  if (dne_ff) begin
                     cur_in   = dfirst_ff;
                     hp_in    = 1'b0;
                     n_in     = '0;
                     state_in = S_TK_STEP;
                  end else begin
                     state_in = S_CHARGE;
                  end
               end
               default: begin
                  state_in = S_SCHED;
               end
            endcase
         end
         S_RM_START: begin
            rp_in    = sp_rd;
            state_in = S_RM_HEAD;
         end
         S_RM_HEAD: begin
            cur_in   = head_rd;
            hp_in    = 1'b0;
            n_in     = '0;
            state_in = S_RM_WALK;
         end
         S_RM_WALK: begin
            // Walk the ready queue until the task is found and unlinked.
            if (cur_ff == wt_ff) begin
               if (tail_rd == wt_ff) begin
                  if (hp_ff) begin
                     tail_we = 1'b1;
                     tail_wd = prev_ff;
                  end else begin
                     bm_in[qp] = 1'b0;
                  end
               end
               if (hp_ff) begin
                  qlink_we = 1'b1;
                  qlink_wa = prev_ff;
                  qlink_wd = qlink_rd;
               end else begin
                  head_we = 1'b1;
                  head_wd = qlink_rd;
               end
               stop = 1'b1;
            end else if (cur_ff == tail_rd || walk_end) begin
               stop = 1'b1;
            end else begin
               prev_in = cur_ff;
               hp_in   = 1'b1;
               cur_in  = qlink_rd;
               n_in    = n_ff + 1'b1;
            end
            if (stop) begin
               inq_in[wt_ff] = 1'b0;
               case (op_ff)
                  OP_UNREADY: state_in = S_FINISH;
                  OP_DELAY:   state_in = S_DL_ADD;
                  default:    state_in = S_PUSH_TAIL;
               endcase
            end
         end
         S_DL_ADD: begin
            sp_we = 1'b1;
            dl_we = 1'b1;
            if (dne_ff) begin
               dlink_we = 1'b1;
               dlink_wa = dlast_ff;
               dlink_wd = wt_ff;
            end else begin
               dfirst_in = wt_ff;
            end
            dlast_in        = wt_ff;
            dne_in          = 1'b1;
            dmark_in[wt_ff] = 1'b1;
            state_in        = S_FINISH;
         end
         S_DR_WALK: begin
            // Walk the delay list to drop one task.
            if (cur_ff == wt_ff) begin
               if (cur_ff == dlast_ff) begin
                  if (hp_ff) begin
                     dlast_in = prev_ff;
                  end else begin
                     dne_in = 1'b0;
                  end
               end
               if (hp_ff) begin
                  dlink_we = 1'b1;
               end else begin
                  dfirst_in = dlink_rd;
               end
               dmark_in[wt_ff] = 1'b0;
               state_in        = S_FINISH;
            end else if (cur_ff == dlast_ff || walk_end) begin
               dmark_in[wt_ff] = 1'b0;
               state_in        = S_FINISH;
            end else begin
               prev_in = cur_ff;
               hp_in   = 1'b1;
               cur_in  = dlink_rd;
               n_in    = n_ff + 1'b1;
            end
         end
         S_TK_STEP: begin
            // Count down one delayed task; unlink it when it expires.
            stop  = cur_ff == dlast_ff || walk_end;
            dl_we = 1'b1;
            dl_wa = cur_ff;
            dl_wd = dl_dec;
            if (expired) begin
               if (cur_ff == dlast_ff) begin
                  if (hp_ff) begin
                     dlast_in = prev_ff;
                  end else begin
                     dne_in = 1'b0;
                  end
               end
               if (hp_ff) begin
                  dlink_we = 1'b1;
               end else begin
                  dfirst_in = dlink_rd;
               end
               dmark_in[cur_ff] = 1'b0;
            end else begin
               prev_in = cur_ff;
               hp_in   = 1'b1;
            end
            nxt_in  = dlink_rd;
            last_in = stop;
            if (expired && !inq_ff[cur_ff]) begin
               state_in = S_TK_PUSH;
            end else if (stop) begin
               state_in = S_CHARGE;
            end else begin
               cur_in = dlink_rd;
               n_in   = n_ff + 1'b1;
            end
         end
         S_TK_PUSH: begin
            // Expired task joins the head of its ready queue.
            if (bm_ff[qp]) begin
               qlink_we = 1'b1;
               qlink_wa = cur_ff;
            end else begin
               tail_we = 1'b1;
               tail_wd = cur_ff;
            end
            head_we        = 1'b1;
            head_wd        = cur_ff;
            bm_in[qp]      = 1'b1;
            inq_in[cur_ff] = 1'b1;
            if (last_ff) begin
               state_in = S_CHARGE;
            end else begin
               cur_in   = nxt_ff;
               n_in     = n_ff + 1'b1;
               state_in = S_TK_STEP;
            end
         end
         S_CHARGE: begin
            // One tick of slice for the running task.
            state_in = S_SCHED;
            if (rv_ff) begin
               sl_we            = 1'b1;
               sl_vld_in[wt_ff] = 1'b1;
               if (sl_dec == '0) begin
                  sl_wd = (tst_ff == '0) ? SLICE_W'(1) : tst_ff;
                  if (inq_ff[wt_ff]) begin
                     state_in = S_RM_START;
                  end
               end
            end
         end
         S_PUSH_TAIL: begin
            if (bm_ff[qp]) begin
               qlink_we = 1'b1;
               qlink_wa = tail_rd;
               qlink_wd = wt_ff;
            end else begin
               head_we = 1'b1;
            end
            tail_we       = 1'b1;
            bm_in[qp]     = 1'b1;
            inq_in[wt_ff] = 1'b1;
            state_in      = S_SCHED;
         end
         S_SCHED: begin
            if (lock_ff == '0 && bm_ff != '0) begin
               rt_in     = head_rd;
               rv_in     = 1'b1;
               sw_in     = 1'b1;
               chosen_in = head_rd;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sw_in    = sw_ff;
               rsp_next_in  = sw_ff ? TASK_ID_W'(chosen_ff) : '0;
               rsp_rdy_in   = RDY_OUT_W'(bm_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Store writes.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[qp] <= head_wd;
      end
      if (tail_we) begin
         tail_ff[qp] <= tail_wd;
      end
      if (qlink_we) begin
         qlink_ff[qlink_wa] <= qlink_wd;
      end
      if (sp_we) begin
         sp_ff[wt_ff] <= prio_ff;
      end
      if (dl_we) begin
         dl_ff[dl_wa] <= dl_wd;
      end
      if (dlink_we) begin
         dlink_ff[dlink_wa] <= dlink_wd;
      end
      if (sl_we) begin
         sl_ff[wt_ff] <= sl_wd;
      end
   end

   // Working and result payload.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ok_ff       <= ok_in;
      prio_ff     <= prio_in;
      ticks_ff    <= ticks_in;
      wt_ff       <= wt_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      nxt_ff      <= nxt_in;
      chosen_ff   <= chosen_in;
      rp_ff       <= rp_in;
      hp_ff       <= hp_in;
      last_ff     <= last_in;
      sw_ff       <= sw_in;
      n_ff        <= n_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_next_ff <= rsp_next_in;
      rsp_rdy_ff  <= rsp_rdy_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bm_ff        <= '0;
         inq_ff       <= '0;
         dmark_ff     <= '0;
         sl_vld_ff    <= '0;
         dfirst_ff    <= '0;
         dlast_ff     <= '0;
         dne_ff       <= 1'b0;
         lock_ff      <= '0;
         rt_ff        <= '0;
         rv_ff        <= 1'b0;
         tst_ff       <= SLICE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bm_ff        <= bm_in;
         inq_ff       <= inq_in;
         dmark_ff     <= dmark_in;
         sl_vld_ff    <= sl_vld_in;
         dfirst_ff    <= dfirst_in;
         dlast_ff     <= dlast_in;
         dne_ff       <= dne_in;
         lock_ff      <= lock_in;
         rt_ff        <= rt_in;
         rv_ff        <= rv_in;
         tst_ff       <= tst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/priority_bitmap_task_scheduler.sv
// Top level of the priority bitmap task scheduler.
// Connects the front end, its command queue and the back end sequencer.
// Depends on pbts_pkg, pbts_front and pbts_back.

// Each item (ready, unready, delay, undelay, lock, unlock, tick, schedule)
// gives one result item. The front end queues up to two items while the
// back end sequencer works on one item at a time, one list step per cycle.
// Ready, lock and schedule need no list walk; unready, delay and undelay
// walk the queue or the delay list; a tick walks the delay list with one
// step per delayed task, one more per woken task, and a queue walk when
// the running task's slice ends.
// A finished result waits in an output register while the next item starts.
// The slice register is always ready and takes effect when a slice is next reloaded.
module priority_bitmap_task_scheduler #(
   parameter int NUM_TASKS = 16,
   parameter int NUM_PRIOS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pbts_pkg::OP_W-1:0]       req_operation,
   input  logic [pbts_pkg::TASK_ID_W-1:0]  req_task_id,
   input  logic [pbts_pkg::PRIO_IN_W-1:0]  req_task_priority,
   input  logic [pbts_pkg::TICKS_W-1:0]    req_delay_ticks,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pbts_pkg::TASK_ID_W-1:0]  rsp_next_task,
   output logic                           rsp_switch_request,
   output logic [pbts_pkg::RDY_OUT_W-1:0]  rsp_ready_priorities,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pbts_pkg::SLICE_W-1:0]    csr_time_slice_ticks
);
   import pbts_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   pbts_front #(
      .NUM_TASKS (NUM_TASKS),
      .NUM_PRIOS (NUM_PRIOS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_delay_ticks   (req_delay_ticks),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd)
   );

   pbts_back #(
      .NUM_TASKS (NUM_TASKS),
      .NUM_PRIOS (NUM_PRIOS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (cmd_valid),
      .cmd_ready            (cmd_ready),
      .cmd                  (cmd),
      .csr_valid            (csr_valid && csr_ready),
      .csr_time_slice_ticks (csr_time_slice_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_task        (rsp_next_task),
      .rsp_switch_request   (rsp_switch_request),
      .rsp_ready_priorities (rsp_ready_priorities)
   );

`ifndef SYNTHESIS
   // A result without a switch names no task.
   a_no_switch_no_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_switch_request |-> rsp_next_task == '0)
      else $error("next task set without a switch request");

   // The back end takes one item and is busy on the following cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready |=> !cmd_ready)
      else $error("back end took an item while busy");

   // The queue is empty and open right after reset.
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready && !cmd_valid)
      else $error("front end not empty after reset");
`endif

endmodule
